// File: design/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the sorted table search unit
// Table geometry, field widths, command codes and the queue entry format.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned WORD_WIDTH  = 32;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned POS_W       = $clog2(TABLE_DEPTH + 1);

  // Port field widths
  localparam int unsigned IDX_FIELD_W = 10;
  localparam int unsigned LEN_FIELD_W = 11;
  localparam int unsigned RAW_W       = 32;

  // Width for range arithmetic, wide enough for every field and the depth
  localparam int unsigned CALC_W = ((POS_W > LEN_FIELD_W) ? POS_W : LEN_FIELD_W) + 1;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // One classified request: a table write or a query with its bounded range
  typedef struct packed {
    logic                  is_query;
    logic [ADDR_W-1:0]     addr;
    logic [WORD_WIDTH-1:0] word;
    logic [POS_W-1:0]      lo;
    logic [POS_W-1:0]      hi;
  } cmd_t;

  // Search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_PROBE,
    ST_FINISH
  } state_e;

endpackage

// File: design/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front: request intake and classification
// Takes requests, drops out-of-depth writes and clamps query ranges.
// ----------------------------------------------------------------------------
module stl_front (
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [stl_pkg::IDX_FIELD_W-1:0] entry_index_i,
  input  logic [stl_pkg::RAW_W-1:0]      entry_value_i,
  input  logic [stl_pkg::IDX_FIELD_W-1:0] range_start_i,
  input  logic [stl_pkg::LEN_FIELD_W-1:0] range_length_i,
  input  logic [stl_pkg::RAW_W-1:0]      search_key_i,
  input  logic                           full_i,
  output logic                           push_o,
  output stl_pkg::cmd_t                  cmd_o
);

  logic [stl_pkg::CALC_W-1:0] start_w;
  logic [stl_pkg::CALC_W-1:0] room_w;
  logic [stl_pkg::CALC_W-1:0] len_w;
  logic                       wr_in_depth;
  logic                       is_query;

  // Clamp start and length to the table
  always_comb begin
    start_w = stl_pkg::CALC_W'(range_start_i);
    if (start_w > stl_pkg::CALC_W'(stl_pkg::TABLE_DEPTH)) begin
      start_w = stl_pkg::CALC_W'(stl_pkg::TABLE_DEPTH);
    end
    room_w = stl_pkg::CALC_W'(stl_pkg::TABLE_DEPTH) - start_w;
    len_w  = stl_pkg::CALC_W'(range_length_i);
    if (len_w > room_w) begin
      len_w = room_w;
    end
  end

  assign is_query    = (mode_i == stl_pkg::MODE_QUERY);
  assign wr_in_depth = stl_pkg::CALC_W'(entry_index_i) < stl_pkg::CALC_W'(stl_pkg::TABLE_DEPTH);

  // Build the queue entry
  always_comb begin
    cmd_o.is_query = is_query;
    cmd_o.addr     = stl_pkg::ADDR_W'(entry_index_i);
    cmd_o.word     = is_query ? stl_pkg::WORD_WIDTH'(search_key_i)
                              : stl_pkg::WORD_WIDTH'(entry_value_i);
    cmd_o.lo       = stl_pkg::POS_W'(start_w);
    cmd_o.hi       = stl_pkg::POS_W'(start_w + len_w);
  end

  // Accept whenever the queue has room; drop writes beyond the table
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && (is_query || wr_in_depth);

endmodule

// File: design/stl_fifo.sv
// ----------------------------------------------------------------------------
// stl_fifo: short command queue
// Decouples request intake from the search sequencer.
// ----------------------------------------------------------------------------
module stl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stl_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output stl_pkg::cmd_t data_o
);

  stl_pkg::cmd_t                 slots_q [stl_pkg::QUEUE_DEPTH];
  logic [stl_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [stl_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [stl_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  function automatic logic [stl_pkg::QPTR_W-1:0] next_ptr(input logic [stl_pkg::QPTR_W-1:0] p);
    if (p == stl_pkg::QPTR_W'(stl_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + stl_pkg::QPTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == stl_pkg::QCNT_W'(stl_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + stl_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - stl_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back: table memory and lower-bound search sequencer
// Executes table writes and runs one binary search probe per cycle.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  stl_pkg::cmd_t            cmd_i,
  output logic                     cmd_pop_o,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_signed_compare_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [stl_pkg::POS_W-1:0] position_o
);

  logic [stl_pkg::WORD_WIDTH-1:0] mem_q [stl_pkg::TABLE_DEPTH];
  logic [stl_pkg::WORD_WIDTH-1:0] rdata_q;
  logic                           mem_we;
  logic                           mem_re;
  logic [stl_pkg::ADDR_W-1:0]     mem_raddr;

  stl_pkg::state_e              state_q, state_d;
  logic                         signed_q;
  logic [stl_pkg::POS_W-1:0]    lo_q, hi_q, end_q, mid_q;
  logic [stl_pkg::WORD_WIDTH-1:0] key_q;
  logic                         eq_q;
  logic                         out_valid_q, out_valid_d;
  logic                         found_q;
  logic [stl_pkg::POS_W-1:0]    position_q;

  logic [stl_pkg::WORD_WIDTH-1:0] sign_mask;
  logic [stl_pkg::WORD_WIDTH-1:0] entry_key;
  logic                         less;
  logic [stl_pkg::POS_W-1:0]    lo_n, hi_n, mid_n, mid_cur;
  logic                         eq_n;
  logic                         more_n;
  logic                         out_free;
  logic                         out_load;
  logic                         take_query;

  function automatic logic [stl_pkg::POS_W-1:0] midpoint(input logic [stl_pkg::POS_W-1:0] lo,
                                                          input logic [stl_pkg::POS_W-1:0] hi);
    return lo + ((hi - lo) >> 1);
  endfunction

  // Flip the sign bit in signed mode so an unsigned compare orders correctly
  assign sign_mask = stl_pkg::WORD_WIDTH'(signed_q) << (stl_pkg::WORD_WIDTH - 1);

  // One probe: compare the entry at mid against the key and narrow the range
  always_comb begin
    entry_key = rdata_q ^ sign_mask;
    less      = entry_key < key_q;
    lo_n      = less ? (mid_q + stl_pkg::POS_W'(1)) : lo_q;
    hi_n      = less ? hi_q : mid_q;
    eq_n      = less ? eq_q : (entry_key == key_q);
    mid_n     = midpoint(lo_n, hi_n);
    more_n    = lo_n < hi_n;
    mid_cur   = midpoint(lo_q, hi_q);
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign cmd_pop_o  = (state_q == stl_pkg::ST_IDLE) && cmd_valid_i;
  assign take_query = cmd_pop_o && cmd_i.is_query;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stl_pkg::ST_IDLE: begin
        if (take_query) begin
          state_d = stl_pkg::ST_LAUNCH;
        end
      end
      stl_pkg::ST_LAUNCH: begin
        state_d = (lo_q < hi_q) ? stl_pkg::ST_PROBE : stl_pkg::ST_FINISH;
      end
      stl_pkg::ST_PROBE: begin
        if (!more_n) begin
          state_d = stl_pkg::ST_FINISH;
        end
      end
      stl_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = stl_pkg::ST_IDLE;
        end
      end
      default: state_d = stl_pkg::ST_IDLE;
    endcase
  end

  // Memory and result controls
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = stl_pkg::ADDR_W'(mid_cur);
    out_load  = 1'b0;
    unique case (state_q)
      stl_pkg::ST_IDLE: begin
        mem_we = cmd_pop_o && !cmd_i.is_query;
      end
      stl_pkg::ST_LAUNCH: begin
        mem_re = 1'b1;
      end
      stl_pkg::ST_PROBE: begin
        mem_re    = more_n;
        mem_raddr = stl_pkg::ADDR_W'(mid_n);
      end
      stl_pkg::ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_i.addr] <= cmd_i.word;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Hold a result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      signed_q    <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        signed_q <= cfg_signed_compare_i;
      end
    end
  end

  // Search bounds, key and result payload
  always_ff @(posedge clk_i) begin
    if (take_query) begin
      lo_q  <= cmd_i.lo;
      hi_q  <= cmd_i.hi;
      end_q <= cmd_i.hi;
      key_q <= cmd_i.word ^ sign_mask;
      eq_q  <= 1'b0;
    end
    if (state_q == stl_pkg::ST_LAUNCH) begin
      mid_q <= mid_cur;
    end
    if (state_q == stl_pkg::ST_PROBE) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      eq_q  <= eq_n;
      mid_q <= mid_n;
    end
    if (out_load) begin
      found_q    <= (lo_q < end_q) && eq_q;
      position_q <= lo_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

endmodule

// File: design/sorted_table_lower_bound_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search_unit: lower-bound search over a sorted table
// Loads table words and answers range queries with found flag and position.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_ready_o   mode, entry_index, entry_value,
//                                              range_start, range_length, search_key
//  out      output     out_valid_o/out_ready_i found, position
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_signed_compare_i
//
//  A write is executed in the sequencer and gives no result.
//  A query runs ceil(log2(length+1)) probes, one registered table read per probe.
//  Reset clears the queue, the sequencer and selects signed compare.
//  Requests are taken while a result waits, until the two-entry queue fills.
//
module sorted_table_lower_bound_search_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [stl_pkg::IDX_FIELD_W-1:0] entry_index_i,
  input  logic [stl_pkg::RAW_W-1:0]       entry_value_i,
  input  logic [stl_pkg::IDX_FIELD_W-1:0] range_start_i,
  input  logic [stl_pkg::LEN_FIELD_W-1:0] range_length_i,
  input  logic [stl_pkg::RAW_W-1:0]       search_key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [stl_pkg::POS_W-1:0]       position_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_signed_compare_i
);

  logic          push;
  logic          full;
  stl_pkg::cmd_t push_cmd;
  logic          cmd_valid;
  logic          cmd_pop;
  stl_pkg::cmd_t head_cmd;

  // Register writes land at once
  assign cfg_ready_o = 1'b1;

  stl_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .range_start_i  (range_start_i),
    .range_length_i (range_length_i),
    .search_key_i   (search_key_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  stl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (head_cmd)
  );

  stl_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_valid_i          (cmd_valid),
    .cmd_i                (head_cmd),
    .cmd_pop_o            (cmd_pop),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_signed_compare_i (cfg_signed_compare_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .found_o              (found_o),
    .position_o           (position_o)
  );

endmodule

// File: verif/lower_bound_checker.sv
// ----------------------------------------------------------------------------
// lower_bound_checker: result checker for the sorted table search unit
// Watches the request, result and config channels, keeps its own copy of the
// table and the compare order, predicts found/position for each search and
// compares every returned result against the oldest prediction.
// ----------------------------------------------------------------------------
module lower_bound_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            mode_i,
  input  logic [stl_pkg::IDX_FIELD_W-1:0] entry_index_i,
  input  logic [stl_pkg::RAW_W-1:0]       entry_value_i,
  input  logic [stl_pkg::IDX_FIELD_W-1:0] range_start_i,
  input  logic [stl_pkg::LEN_FIELD_W-1:0] range_length_i,
  input  logic [stl_pkg::RAW_W-1:0]       search_key_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            found_i,
  input  logic [stl_pkg::POS_W-1:0]       position_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic                            cfg_signed_compare_i,
  output int unsigned                     pending_o,
  output int unsigned                     fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [stl_pkg::WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic                     found;
    logic [stl_pkg::POS_W-1:0] position;
  } search_result_t;

  word_t          word_store [stl_pkg::TABLE_DEPTH];
  logic           signed_order;
  search_result_t expected_results [$];
  int unsigned    mismatch_cnt = 0;

  // Order test under the selected compare mode
  function automatic logic word_below(word_t a, word_t b);
    if (signed_order) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  // Lower-bound binary search over the clamped range of the local table copy
  function automatic search_result_t predict_lower_bound(
    logic [stl_pkg::IDX_FIELD_W-1:0] start,
    logic [stl_pkg::LEN_FIELD_W-1:0] span,
    word_t                           key
  );
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    span_end;
    int unsigned    mid;
    search_result_t res;
    lo = start;
    if (lo > stl_pkg::TABLE_DEPTH) lo = stl_pkg::TABLE_DEPTH;
    span_end = span;
    if (span_end > stl_pkg::TABLE_DEPTH - lo) span_end = stl_pkg::TABLE_DEPTH - lo;
    span_end = lo + span_end;
    hi = span_end;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (word_below(word_store[mid], key)) lo = mid + 1;
      else hi = mid;
    end
    res.found = (lo < span_end) && (word_store[lo] == key);
    res.position = lo[stl_pkg::POS_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    search_result_t oldest;
    if (!rst_ni) begin
      signed_order <= 1'b1;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // Compare a delivered result before queueing any new search
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no search pending: found %0d position %0d", found_i, position_i);
          mismatch_cnt++;
        end else begin
          oldest = expected_results.pop_front();
          if (found_i !== oldest.found) begin
            $error("found: expected %0d, got %0d", oldest.found, found_i);
            mismatch_cnt++;
          end
          if (position_i !== oldest.position) begin
            $error("position: expected %0d, got %0d", oldest.position, position_i);
            mismatch_cnt++;
          end
        end
      end

      // Apply a table write or predict a search
      if (in_valid_i && in_ready_i) begin
        if (mode_i == stl_pkg::MODE_WRITE) begin
          if (entry_index_i < stl_pkg::TABLE_DEPTH)
            word_store[entry_index_i] = entry_value_i[stl_pkg::WORD_WIDTH-1:0];
        end else begin
          expected_results.push_back(predict_lower_bound(range_start_i, range_length_i,
                                                         search_key_i[stl_pkg::WORD_WIDTH-1:0]));
        end
      end

      // Track the compare order
      if (cfg_valid_i && cfg_ready_i) signed_order <= cfg_signed_compare_i;

      pending_o <= expected_results.size();
    end
    fail_count_o <= mismatch_cnt;
  end

endmodule

// File: verif/tb_sorted_table_lower_bound_search_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_lower_bound_search_unit: testbench of the table search unit
// Loads sorted table segments in signed and unsigned order, fires searches
// over full, partial, empty and end-saturated ranges with random idling on
// both channels, and leaves all checking to the lower_bound_checker.
// ----------------------------------------------------------------------------
module tb_sorted_table_lower_bound_search_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES    = 32;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS     = 500;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            mode = stl_pkg::MODE_WRITE;
  logic [stl_pkg::IDX_FIELD_W-1:0] entry_index = '0;
  logic [stl_pkg::RAW_W-1:0]       entry_value = '0;
  logic [stl_pkg::IDX_FIELD_W-1:0] range_start = '0;
  logic [stl_pkg::LEN_FIELD_W-1:0] range_length = '0;
  logic [stl_pkg::RAW_W-1:0]       search_key = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            found;
  logic [stl_pkg::POS_W-1:0]       position;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_signed_compare = 1'b1;
  int unsigned                     pending;
  int unsigned                     fail_count;

  // Stimulus bookkeeping
  logic                            order_signed = 1'b1;
  logic                            burst_mode = 1'b0;
  int unsigned                     hold_req = 0;
  int unsigned                     n_writes = 0;
  int unsigned                     n_searches = 0;
  int unsigned                     n_cfg = 0;
  int unsigned                     seg_base;
  int unsigned                     seg_n;
  logic [stl_pkg::RAW_W-1:0]       seg_words [$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sorted_table_lower_bound_search_unit u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .mode_i               (mode),
    .entry_index_i        (entry_index),
    .entry_value_i        (entry_value),
    .range_start_i        (range_start),
    .range_length_i       (range_length),
    .search_key_i         (search_key),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .found_o              (found),
    .position_o           (position),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_signed_compare_i (cfg_signed_compare)
  );

  lower_bound_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .mode_i               (mode),
    .entry_index_i        (entry_index),
    .entry_value_i        (entry_value),
    .range_start_i        (range_start),
    .range_length_i       (range_length),
    .search_key_i         (search_key),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .found_i              (found),
    .position_i           (position),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_i          (cfg_ready),
    .cfg_signed_compare_i (cfg_signed_compare),
    .pending_o            (pending),
    .fail_count_o         (fail_count)
  );

  // Map a value in compare order space to raw word bits
  function automatic logic [stl_pkg::RAW_W-1:0] from_order(logic [stl_pkg::RAW_W-1:0] ord);
    return order_signed ? (ord ^ 32'h8000_0000) : ord;
  endfunction

  // Offer one request, hold it until accepted, then maybe idle
  task automatic push_request(
    logic                            req_mode,
    logic [stl_pkg::IDX_FIELD_W-1:0] idx,
    logic [stl_pkg::RAW_W-1:0]       value,
    logic [stl_pkg::IDX_FIELD_W-1:0] start,
    logic [stl_pkg::LEN_FIELD_W-1:0] span,
    logic [stl_pkg::RAW_W-1:0]       key
  );
    int unsigned gap;
    in_valid     <= 1'b1;
    mode         <= req_mode;
    entry_index  <= idx;
    entry_value  <= value;
    range_start  <= start;
    range_length <= span;
    search_key   <= key;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (req_mode == stl_pkg::MODE_WRITE) n_writes++;
    else n_searches++;
    if (burst_mode || $urandom_range(0, 1) == 0) return;
    gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic write_entry(logic [stl_pkg::IDX_FIELD_W-1:0] idx,
                             logic [stl_pkg::RAW_W-1:0] value);
    push_request(stl_pkg::MODE_WRITE, idx, value, stl_pkg::IDX_FIELD_W'($urandom()),
                 stl_pkg::LEN_FIELD_W'($urandom()), $urandom());
  endtask

  task automatic search(logic [stl_pkg::IDX_FIELD_W-1:0] start,
                        logic [stl_pkg::LEN_FIELD_W-1:0] span,
                        logic [stl_pkg::RAW_W-1:0] key);
    push_request(stl_pkg::MODE_QUERY, stl_pkg::IDX_FIELD_W'($urandom()), $urandom(),
                 start, span, key);
  endtask

  // Drop valid, drain every outstanding result, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic signed_sel);
    wait_idle();
    cfg_valid          <= 1'b1;
    cfg_signed_compare <= signed_sel;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid    <= 1'b0;
    order_signed = signed_sel;
    n_cfg++;
  endtask

  // Place a new segment and fill it with words sorted in the current order
  task automatic load_segment();
    int unsigned               i;
    int unsigned               pick;
    logic [stl_pkg::RAW_W-1:0] pool;
    logic [stl_pkg::RAW_W-1:0] ord [$];
    int unsigned               slots [$];
    seg_n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(3, 24);
    pick = $urandom_range(0, 99);
    if (pick < 25) seg_base = stl_pkg::TABLE_DEPTH - seg_n;
    else if (pick < 40) seg_base = 0;
    else seg_base = $urandom_range(0, stl_pkg::TABLE_DEPTH - seg_n);
    pool = $urandom();
    for (i = 0; i < seg_n; i++) begin
      pick = $urandom_range(0, 99);
      if (i > 0 && pick < 25) ord.push_back(ord[i-1]);
      else if (pick < 55) ord.push_back(pool + $urandom_range(0, 15));
      else if (pick < 62) ord.push_back('0);
      else if (pick < 69) ord.push_back('1);
      else ord.push_back($urandom());
    end
    ord.sort();
    seg_words.delete();
    for (i = 0; i < seg_n; i++) begin
      seg_words.push_back(from_order(ord[i]));
      slots.push_back(i);
    end
    // Write in shuffled order; searches only start once the whole segment is in
    slots.shuffle();
    foreach (slots[k]) begin
      write_entry(stl_pkg::IDX_FIELD_W'(seg_base + slots[k]), seg_words[slots[k]]);
    end
  endtask

  // One search inside the current segment, or an empty range anywhere
  task automatic random_search();
    int unsigned               s;
    int unsigned               span;
    int unsigned               pick;
    logic [stl_pkg::RAW_W-1:0] w;
    logic [stl_pkg::RAW_W-1:0] key;
    s = $urandom_range(0, seg_n - 1);
    span = $urandom_range(0, seg_n - s);
    if (seg_base + seg_n == stl_pkg::TABLE_DEPTH && $urandom_range(0, 99) < 30)
      span = $urandom_range(seg_n - s, 2047);
    w = seg_words[$urandom_range(0, seg_n - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 40) key = w;
    else if (pick < 55) key = w + 1;
    else if (pick < 65) key = w - 1;
    else if (pick < 72) key = from_order('0);
    else if (pick < 79) key = from_order('1);
    else key = $urandom();
    if ($urandom_range(0, 99) < 8) begin
      search(stl_pkg::IDX_FIELD_W'($urandom()), '0, key);
    end else begin
      search(stl_pkg::IDX_FIELD_W'(seg_base + s), stl_pkg::LEN_FIELD_W'(span), key);
    end
  endtask

  // Result side: random backpressure plus long holds on request
  initial begin : receiver
    int unsigned hold_done;
    int unsigned span;
    hold_done = 0;
    @(posedge clk_i);
    forever begin
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_done++;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        span = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (span) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned directed_items;
    int unsigned phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: signed order after reset, segment at the top end of the table
    write_entry(10'd1016, 32'h8000_0000);
    write_entry(10'd1017, 32'hFFFF_FFFF);
    write_entry(10'd1018, 32'h0000_0000);
    write_entry(10'd1019, 32'h0000_0000);
    write_entry(10'd1020, 32'h0000_0005);
    write_entry(10'd1021, 32'h0000_0005);
    write_entry(10'd1022, 32'h7FFF_FFFE);
    write_entry(10'd1023, 32'h7FFF_FFFF);
    search(10'd1016, 11'd8, 32'h8000_0000);
    search(10'd1016, 11'd8, 32'h7FFF_FFFF);
    search(10'd1016, 11'd8, 32'h0000_0003);
    search(10'd1016, 11'd2047, 32'h0000_0005);
    search(10'd1023, 11'd1, 32'h0000_0000);
    search(10'd1023, 11'd0, 32'h0000_0000);
    search(10'd0, 11'd0, 32'hFFFF_FFFF);
    search(10'd1016, 11'd4, 32'h0000_0005);
    search(10'd1019, 11'd5, 32'h8000_0000);
    directed_items = n_writes + n_searches;

    // Random phases: optional order change, new segment, a run of searches
    phase = 0;
    while (n_writes + n_searches - directed_items < RANDOM_ITEMS) begin
      if (phase == 0) write_config(1'b0);
      else if (phase == 1) write_config(1'b1);
      else if ($urandom_range(0, 2) == 0) write_config(1'($urandom_range(0, 1)));
      burst_mode = ($urandom_range(0, 3) == 0);
      load_segment();
      if (phase == 2) begin
        // Stall the result side while searches keep coming back to back
        hold_req <= hold_req + 1;
        burst_mode = 1'b1;
      end
      repeat ($urandom_range(10, 25)) random_search();
      if (phase == 4) wait_idle();
      phase++;
    end

    wait_idle();
    $display("covered %0d table writes and %0d searches over %0d segments, %0d order changes",
             n_writes, n_searches, phase, n_cfg);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_table_lower_bound_search_unit: match");
    end else begin
      $display("sorted_table_lower_bound_search_unit: mismatch");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin : watchdog
    #5_000_000;
    $display("sorted_table_lower_bound_search_unit: mismatch");
    $finish;
  end

endmodule
